// ===== src/rgbwb_pkg.sv =====
// Package for the RGB 16-bit weighted blend block.
// Holds the scaling constants, the configuration register indexes and the stage load struct.
// No dependencies.
`default_nettype none

package rgbwb_pkg;

  localparam int unsigned CHAN_W   = 5;
  localparam int unsigned PIX_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [31:0] SCALE_MUL   = 32'h8421_0843;
  localparam int unsigned SCALE_SHIFT = 36;
  localparam logic [31:0] FADE_MUL    = 32'h8080_8081;
  localparam int unsigned FADE_SHIFT  = 39;
  localparam logic [7:0]  FADE_OFF    = 8'hff;
  localparam logic [CHAN_W-1:0] WEIGHT_MAX = 5'd31;

  localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEVEL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_IS_565 = 1'b1;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } load_t;

endpackage

`default_nettype wire

// ===== src/rgbwb_in_if.sv =====
// Input channel of the blend block: one source and destination pixel pair per transfer.
// Depends on nothing.
`default_nettype none

interface rgbwb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] src_pixel;
  logic [15:0] dest_pixel;
  logic [4:0]  weight;
  logic        src_is_565;
  logic        src_alpha;

  modport source (output valid, src_pixel, dest_pixel, weight, src_is_565, src_alpha,
                  input ready);
  modport sink (input valid, src_pixel, dest_pixel, weight, src_is_565, src_alpha,
                output ready);
endinterface

`default_nettype wire

// ===== src/rgbwb_out_if.sv =====
// Output channel of the blend block: one blended pixel per transfer.
// Depends on nothing.
`default_nettype none

interface rgbwb_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] blended_pixel;

  modport source (output valid, blended_pixel, input ready);
  modport sink (input valid, blended_pixel, output ready);
endinterface

`default_nettype wire

// ===== src/rgbwb_cfg_if.sv =====
// Configuration write channel of the blend block: register index and write data.
// Depends on nothing.
`default_nettype none

interface rgbwb_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/rgbwb_scale.sv =====
// Pipelined channel scaler: weight times channel over 31, then the optional fade over 255.
// Three register stages; depends on rgbwb_pkg.
`default_nettype none

module rgbwb_scale (
  input  wire logic                         clk,
  input  wire rgbwb_pkg::load_t             load,
  input  wire logic [rgbwb_pkg::CHAN_W-1:0] weight,
  input  wire logic [rgbwb_pkg::CHAN_W-1:0] chan,
  input  wire logic [7:0]                   fade_level,
  output logic [7:0]                        contrib
);

  logic [9:0]  prod2;
  logic [4:0]  chan2;
  logic [41:0] wide3;
  logic [4:0]  w3;
  logic [4:0]  chan3;
  logic [12:0] x4;
  logic [4:0]  w4;
  logic        fade4;
  logic [44:0] wide5;
  logic [4:0]  f5;

  assign wide3 = {32'd0, prod2} * {10'd0, rgbwb_pkg::SCALE_MUL};

  always_ff @(posedge clk) begin
    if (load.s2) begin
      prod2 <= {5'd0, weight} * {5'd0, chan};
      chan2 <= chan;
    end
    if (load.s3) begin
      w3    <= wide3[rgbwb_pkg::SCALE_SHIFT +: 5];
      chan3 <= chan2;
    end
    if (load.s4) begin
      x4    <= {8'd0, w3} * {5'd0, fade_level};
      w4    <= w3;
      fade4 <= (fade_level != rgbwb_pkg::FADE_OFF) && (w3 != chan3);
    end
  end

  assign wide5 = {32'd0, x4} * {13'd0, rgbwb_pkg::FADE_MUL};
  assign f5    = wide5[rgbwb_pkg::FADE_SHIFT +: 5];

  always_comb begin
    if (fade4) begin
      contrib = {f5, 3'd0};
    end else begin
      contrib = {w4, 3'd0};
    end
  end

endmodule

`default_nettype wire

// ===== src/rgb16_weighted_blend_top.sv =====
// Top level of the RGB 16-bit weighted blend block.
// Depends on rgbwb_pkg, the three channel interfaces and rgbwb_scale.
//
// The block takes one pixel pair per clock while the output is not stalled, and returns one
// blended pixel per pair, in order. The pipe has five register stages: input capture,
// weight product, divide by 31, fade product, and the fade divide with the channel sums
// feeding the output register. Each stage holds its item while the stage after it is full
// and cannot pass its own item on, so back-pressure stalls the pipe without loss.
// Configuration writes are always taken.
`default_nettype none

module rgb16_weighted_blend_top (
  input  wire logic   clk,
  input  wire logic   rst,
  rgbwb_in_if.sink    pix_in,
  rgbwb_out_if.source pix_out,
  rgbwb_cfg_if.sink   cfg
);

  logic [7:0] fade_level;
  logic       dest_is_565;

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  rgbwb_pkg::load_t load;

  logic [4:0]       t1;
  logic             alpha1, alpha2, alpha3, alpha4;
  logic             d5651, d5652, d5653, d5654;
  logic [2:0][7:0]  s8_1, s8_2, s8_3, s8_4;
  logic [2:0][4:0]  sc1, dc1;
  logic [2:0][7:0]  s8_in, d8_in;
  logic [4:0]       tn1;
  logic [2:0][7:0]  src_contrib, dst_contrib, sum5;
  logic [15:0]      res_next;
  logic [15:0]      res5;

  function automatic logic [2:0][7:0] unpack(input logic [15:0] p, input logic is565);
    logic [2:0][7:0] c;
    if (is565) begin
      c[2] = {p[15:11], p[15:13]};
      c[1] = {p[10:5], p[10:9]};
    end else begin
      c[2] = {p[14:10], p[14:12]};
      c[1] = {p[9:5], p[9:7]};
    end
    c[0] = {p[4:0], p[4:2]};
    return c;
  endfunction

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_level  <= 8'hff;
      dest_is_565 <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rgbwb_pkg::CFG_FADE_LEVEL:  fade_level  <= cfg.data;
        rgbwb_pkg::CFG_DEST_IS_565: dest_is_565 <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign rdy5 = !v5 || pix_out.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pix_in.ready = rdy1;
  assign load = '{s2: rdy2, s3: rdy3, s4: rdy4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pix_in.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  assign s8_in = unpack(pix_in.src_pixel, pix_in.src_is_565);
  assign d8_in = unpack(pix_in.dest_pixel, dest_is_565);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1     <= pix_in.weight;
      alpha1 <= pix_in.src_alpha;
      d5651  <= dest_is_565;
      s8_1   <= s8_in;
      for (int i = 0; i < 3; i++) begin
        sc1[i] <= s8_in[i][7:3];
        dc1[i] <= d8_in[i][7:3];
      end
    end
    if (rdy2) begin
      alpha2 <= alpha1;
      d5652  <= d5651;
      s8_2   <= s8_1;
    end
    if (rdy3) begin
      alpha3 <= alpha2;
      d5653  <= d5652;
      s8_3   <= s8_2;
    end
    if (rdy4) begin
      alpha4 <= alpha3;
      d5654  <= d5653;
      s8_4   <= s8_3;
    end
    if (rdy5) begin
      res5 <= res_next;
    end
  end

  assign tn1 = rgbwb_pkg::WEIGHT_MAX - t1;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    rgbwb_scale u_src (
      .clk        (clk),
      .load       (load),
      .weight     (tn1),
      .chan       (sc1[ch]),
      .fade_level (fade_level),
      .contrib    (src_contrib[ch])
    );

    rgbwb_scale u_dst (
      .clk        (clk),
      .load       (load),
      .weight     (t1),
      .chan       (dc1[ch]),
      .fade_level (fade_level),
      .contrib    (dst_contrib[ch])
    );

    assign sum5[ch] = (alpha4 ? src_contrib[ch] : s8_4[ch]) + dst_contrib[ch];
  end

  always_comb begin
    if (d5654) begin
      res_next = {sum5[2][7:3], sum5[1][7:2], sum5[0][7:3]};
    end else begin
      res_next = {1'b0, sum5[2][7:3], sum5[1][7:3], sum5[0][7:3]};
    end
  end

  assign pix_out.valid         = v5;
  assign pix_out.blended_pixel = res5;

endmodule

`default_nettype wire
